// ----- rtl/binary_to_decimal_ascii_core_assert.svh -----
// assertion macros for the decimal ascii converter
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define B2DA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2da check failed");
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2da check failed");
`else
`define B2DA_ASSERT_NOW(label, clk, rst, ante, cons)
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/b2da_pkg.sv -----
// shared types and constants for the decimal ascii converter
package b2da_pkg;

  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned DIGIT_IDX_W     = 4;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned QUEUE_DEPTH     = 8;
  localparam int unsigned PTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;
  typedef logic [DIGIT_IDX_W-1:0]     digit_idx_t;

  typedef struct packed {
    logic       neg;
    logic [7:0] size;
  } meta_t;

  typedef struct packed {
    bcd_t       bcd;
    digit_idx_t nd;
    logic       neg;
    logic       err;
  } entry_t;

endpackage

// ----- rtl/b2da_front.sv -----
// input register: sign detection and magnitude
module b2da_front #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned PAD_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          value_bits,
  input  logic                 signed_mode,
  input  logic [7:0]           buffer_size,
  output logic                 valid,
  output logic [PAD_WIDTH-1:0] mag,
  output b2da_pkg::meta_t      meta
);

  localparam int unsigned MAG_W   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  // wider widths zero-extend the 32-bit field, so the sign bit is never set
  localparam bit          SIGN_ON = (VALUE_WIDTH <= 32);

  logic [MAG_W-1:0] raw;
  logic [MAG_W-1:0] mag_next;
  logic             neg_next;

  always_comb begin
    raw      = value_bits[MAG_W-1:0];
    neg_next = SIGN_ON && signed_mode && raw[MAG_W-1];
    mag_next = neg_next ? MAG_W'(~raw + MAG_W'(1)) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= PAD_WIDTH'(mag_next);
    meta.neg  <= neg_next;
    meta.size <= buffer_size;
  end

endmodule

// ----- rtl/b2da_dabble.sv -----
// one pipeline stage of shift-and-add-3 binary to bcd conversion
module b2da_dabble #(
  parameter int unsigned PAD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  b2da_pkg::bcd_t       in_bcd,
  input  logic [PAD_WIDTH-1:0] in_bits,
  input  b2da_pkg::meta_t      in_meta,
  output logic                 valid,
  output b2da_pkg::bcd_t       bcd,
  output logic [PAD_WIDTH-1:0] bits,
  output b2da_pkg::meta_t      meta
);

  b2da_pkg::bcd_t       bcd_next;
  logic [PAD_WIDTH-1:0] bits_next;

  always_comb begin
    bcd_next  = in_bcd;
    bits_next = in_bits;
    for (int s = 0; s < b2da_pkg::STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < b2da_pkg::NUM_DIGITS; d++) begin
        if (bcd_next[d] >= 4'd5) begin
          bcd_next[d] = bcd_next[d] + 4'd3;
        end
      end
      bcd_next  = b2da_pkg::bcd_t'({bcd_next, bits_next[PAD_WIDTH-1]});
      bits_next = bits_next << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bcd  <= bcd_next;
    bits <= bits_next;
    meta <= in_meta;
  end

endmodule

// ----- rtl/b2da_emit.sv -----
// length check, result queue and character serialiser
module b2da_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  b2da_pkg::bcd_t  in_bcd,
  input  b2da_pkg::meta_t in_meta,
  output logic            strobe,
  output logic [7:0]      out_char,
  output logic            too_small,
  output logic            last_char
);

  b2da_pkg::entry_t                   slot [b2da_pkg::QUEUE_DEPTH];
  logic [b2da_pkg::PTR_W-1:0]         wr_ptr;
  logic [b2da_pkg::PTR_W-1:0]         rd_ptr;
  logic [b2da_pkg::COUNT_W-1:0]       fill;
  logic [3:0]                         pos;

  b2da_pkg::entry_t                   new_entry;
  b2da_pkg::digit_idx_t               nd;
  logic [4:0]                         need;

  b2da_pkg::entry_t                   head;
  logic                               emit;
  logic                               pop;
  logic [3:0]                         k;
  b2da_pkg::digit_idx_t               idx;
  logic [7:0]                         char_next;
  logic                               err_next;
  logic                               last_next;

  // digit count and buffer check on the finished bcd word
  always_comb begin
    nd = b2da_pkg::digit_idx_t'(1);
    for (int d = 0; d < b2da_pkg::NUM_DIGITS; d++) begin
      if (in_bcd[d] != 4'd0) begin
        nd = b2da_pkg::digit_idx_t'(d + 1);
      end
    end
    need          = 5'(nd) + 5'(in_meta.neg) + 5'd1;
    new_entry.bcd = in_bcd;
    new_entry.nd  = nd;
    new_entry.neg = in_meta.neg;
    new_entry.err = {3'b000, need} > in_meta.size;
  end

  always_comb begin
    head      = slot[rd_ptr];
    emit      = (fill != '0);
    k         = pos - 4'(head.neg);
    idx       = head.nd - 4'd1 - k;
    char_next = b2da_pkg::CHAR_NUL;
    err_next  = 1'b0;
    last_next = 1'b0;
    if (head.err) begin
      err_next  = 1'b1;
      last_next = 1'b1;
    end else if (head.neg && pos == 4'd0) begin
      char_next = b2da_pkg::CHAR_MINUS;
    end else if (k == head.nd) begin
      last_next = 1'b1;
    end else begin
      char_next = b2da_pkg::CHAR_ZERO + {4'd0, head.bcd[idx]};
    end
    pop = emit && last_next;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      slot[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      pos    <= '0;
      strobe <= 1'b0;
    end else begin
      if (in_valid) begin
        wr_ptr <= wr_ptr + b2da_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + b2da_pkg::PTR_W'(1);
      end
      fill <= fill + b2da_pkg::COUNT_W'(in_valid) - b2da_pkg::COUNT_W'(pop);
      if (pop) begin
        pos <= '0;
      end else if (emit) begin
        pos <= pos + 4'd1;
      end
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    out_char  <= char_next;
    too_small <= err_next;
    last_char <= last_next;
  end

endmodule

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// top level of the decimal ascii converter
// A word is taken when start is high and busy is low, and may follow in the
// very next cycle. The value passes an input register and one shift-and-add-3
// stage per four bits of magnitude (eight for a width of 32), then waits in an
// eight-word result queue, from whose head its characters pass through an
// output register onto strobe. Characters then leave one per cycle with no gaps:
// sign, digits and terminator, 2 to 12 characters per word for a width of 32,
// or a single too_small result. Busy rises while eight accepted words are not
// yet fully sent, so strobe can never be held off and never overruns the queue.
// A word's place is free again in the cycle after its last result, so the
// character port sets the sustained rate except in a run of too_small
// results, which is held by the eight places of the queue.
module binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_bits,
  input  logic        signed_mode,
  input  logic [7:0]  buffer_size,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        too_small,
  output logic        last_char
);

  `include "binary_to_decimal_ascii_core_assert.svh"

  localparam int unsigned MAG_W     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned NSTAGES   =
    (MAG_W + b2da_pkg::STEPS_PER_STAGE - 1) / b2da_pkg::STEPS_PER_STAGE;
  localparam int unsigned PAD_WIDTH = NSTAGES * b2da_pkg::STEPS_PER_STAGE;
  localparam logic [b2da_pkg::COUNT_W-1:0] CREDITS_MAX  =
    b2da_pkg::COUNT_W'(b2da_pkg::QUEUE_DEPTH);
  localparam logic [b2da_pkg::COUNT_W-1:0] CREDITS_LAST =
    b2da_pkg::COUNT_W'(b2da_pkg::QUEUE_DEPTH - 1);

  logic                           accept;
  logic                           release_word;
  logic [b2da_pkg::COUNT_W-1:0]   credits;

  logic                           stg_valid [NSTAGES+1];
  b2da_pkg::bcd_t                 stg_bcd   [NSTAGES+1];
  logic [PAD_WIDTH-1:0]           stg_bits  [NSTAGES+1];
  b2da_pkg::meta_t                stg_meta  [NSTAGES+1];

  assign accept       = start && !busy;
  assign release_word = strobe && last_char;
  assign busy         = (credits == CREDITS_MAX);
  assign stg_bcd[0]   = '0;

  // words in flight or queued; freed when the terminator or error leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + b2da_pkg::COUNT_W'(accept)
                 - b2da_pkg::COUNT_W'(release_word);
    end
  end

  b2da_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .PAD_WIDTH   (PAD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .value_bits  (value_bits),
    .signed_mode (signed_mode),
    .buffer_size (buffer_size),
    .valid       (stg_valid[0]),
    .mag         (stg_bits[0]),
    .meta        (stg_meta[0])
  );

  for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
    b2da_dabble #(
      .PAD_WIDTH (PAD_WIDTH)
    ) u_dabble (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stg_valid[g]),
      .in_bcd   (stg_bcd[g]),
      .in_bits  (stg_bits[g]),
      .in_meta  (stg_meta[g]),
      .valid    (stg_valid[g+1]),
      .bcd      (stg_bcd[g+1]),
      .bits     (stg_bits[g+1]),
      .meta     (stg_meta[g+1])
    );
  end

  b2da_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[NSTAGES]),
    .in_bcd    (stg_bcd[NSTAGES]),
    .in_meta   (stg_meta[NSTAGES]),
    .strobe    (strobe),
    .out_char  (out_char),
    .too_small (too_small),
    .last_char (last_char)
  );

  `B2DA_ASSERT_NOW(a_credit_bound, clk, rst, 1'b1, credits <= CREDITS_MAX)
  `B2DA_ASSERT_NOW(a_error_is_last, clk, rst, strobe && too_small, last_char && out_char == 8'h00)
  `B2DA_ASSERT_NOW(a_nul_is_last, clk, rst, strobe && out_char == b2da_pkg::CHAR_NUL, last_char)
  `B2DA_ASSERT_NEXT(a_full_blocks, clk, rst, accept && !release_word && credits == CREDITS_LAST, busy)

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the decimal ascii converter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned RANDOM_WORDS  = 150;
  localparam int unsigned WATCHDOG_MAX  = 1000;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } char_res_t;

  class ascii_scoreboard;
    char_res_t expected_q[$];
    int        errors;
    int        words;
    int        refused;
    int        negatives;
    int        chars;

    // sign and digits of a value, most significant first, no terminator
    static function text_q_t chars_of(logic [31:0] v, logic sgn);
      text_q_t     txt;
      logic [31:0] mag;
      logic        neg;
      neg = sgn && v[31];
      mag = neg ? (~v + 32'd1) : v;
      do begin
        txt.push_front(b2da_pkg::CHAR_ZERO + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      if (neg) txt.push_front(b2da_pkg::CHAR_MINUS);
      return txt;
    endfunction

    function void note_word(logic [31:0] v, logic sgn, logic [7:0] sz);
      text_q_t txt;
      txt = chars_of(v, sgn);
      words++;
      if (sgn && v[31]) negatives++;
      if (txt.size() + 1 > sz) begin
        refused++;
        expected_q.push_back(char_res_t'{b2da_pkg::CHAR_NUL, 1'b1, 1'b1});
      end else begin
        foreach (txt[i]) expected_q.push_back(char_res_t'{txt[i], 1'b0, 1'b0});
        expected_q.push_back(char_res_t'{b2da_pkg::CHAR_NUL, 1'b0, 1'b1});
      end
    endfunction

    function void check_char(logic [7:0] ch, logic err, logic last);
      char_res_t exp_c;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_char %h too_small %b last_char %b", ch, err, last);
        errors++;
        return;
      end
      exp_c = expected_q.pop_front();
      chars++;
      if (ch !== exp_c.ch) begin
        $error("out_char: expected %h, got %h", exp_c.ch, ch);
        errors++;
      end
      if (err !== exp_c.err) begin
        $error("too_small: expected %b, got %b", exp_c.err, err);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last_char: expected %b, got %b", exp_c.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] value_bits;
  logic        signed_mode;
  logic [7:0]  buffer_size;
  logic        strobe;
  logic [7:0]  out_char;
  logic        too_small;
  logic        last_char;

  ascii_scoreboard sb = new();
  int unsigned     idle_cycles;

  binary_to_decimal_ascii_core #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .signed_mode(signed_mode),
    .buffer_size(buffer_size),
    .strobe     (strobe),
    .out_char   (out_char),
    .too_small  (too_small),
    .last_char  (last_char)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_char(out_char, too_small, last_char);
  end

  // watchdog on cycles where no word is taken and no result comes out
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_MAX, sb.pending());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // hold start high until the word is taken, then record it
  task automatic send_word(logic [31:0] v, logic sgn, logic [7:0] sz);
    @(negedge clk);
    start       <= 1'b1;
    value_bits  <= v;
    signed_mode <= sgn;
    buffer_size <= sz;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_word(v, sgn, sz);
  endtask

  // random junk on the fields while start is low
  task automatic go_idle(int unsigned n);
    @(negedge clk);
    start       <= 1'b0;
    value_bits  <= $urandom;
    signed_mode <= 1'($urandom_range(0, 1));
    buffer_size <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    go_idle(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [31:0] v;
    logic        sgn;
    int          need;
    int          sz;
    int unsigned pick;
    text_q_t     txt;
    v   = $urandom >> $urandom_range(0, 31);
    sgn = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    if (pick == 0) v = 32'h8000_0000;
    else if (pick == 1) v = 32'hffff_ffff;
    else if (pick == 2) v = 32'h0000_0000;
    else if (pick < 7) v = ~v + 32'd1;   // lands in the negative half for v from 1 to 2**31
    txt  = ascii_scoreboard::chars_of(v, sgn);
    need = txt.size() + 1;
    pick = $urandom_range(0, 9);
    if (pick < 7) sz = need + $urandom_range(0, 3);
    else if (pick == 7) sz = need - 1;
    else if (pick == 8) sz = $urandom_range(0, 255);
    else sz = $urandom_range(0, 1) ? 255 : 0;
    send_word(v, sgn, 8'(sz));
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    rst         = 1'b1;
    start       = 1'b0;
    value_bits  = '0;
    signed_mode = 1'b0;
    buffer_size = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: edges of range, exact fits and one-short buffers
    send_word(32'h0000_0000, 1'b0, 8'd2);
    send_word(32'h0000_0000, 1'b1, 8'd1);
    send_word(32'h0000_0000, 1'b0, 8'd0);
    send_word(32'hffff_ffff, 1'b0, 8'd11);
    send_word(32'hffff_ffff, 1'b0, 8'd10);
    send_word(32'hffff_ffff, 1'b1, 8'd3);
    send_word(32'hffff_ffff, 1'b1, 8'd2);
    send_word(32'h8000_0000, 1'b1, 8'd12);
    send_word(32'h8000_0000, 1'b1, 8'd11);
    send_word(32'h8000_0000, 1'b0, 8'd11);
    send_word(32'h7fff_ffff, 1'b1, 8'd11);
    send_word(32'h7fff_ffff, 1'b0, 8'd255);
    send_word(32'd9, 1'b0, 8'd2);
    send_word(32'd10, 1'b0, 8'd3);
    send_word(32'd10, 1'b0, 8'd2);
    send_word(32'd99, 1'b1, 8'd3);
    send_word(32'd100, 1'b1, 8'd4);
    send_word(32'hffff_fffb, 1'b1, 8'd3);
    send_word(32'hffff_fff6, 1'b1, 8'd4);
    send_word(32'd1234567890, 1'b0, 8'd128);
    send_word(32'h8000_0001, 1'b1, 8'd255);
    send_word(32'hdead_beef, 1'b0, 8'd0);
    drain();

    // random bursts with random gaps
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_random_word();
        sent++;
        if (sent == RANDOM_WORDS / 2) drain();
      end
      go_idle($urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 6));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d negative, %0d refused as too small), %0d results checked",
             sb.words, sb.negatives, sb.refused, sb.chars);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
